// ===== rtl/bootloader_flash_programmer_assert.svh =====
// Assertion macros shared by the checker files of the flash programmer.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef BOOTLOADER_FLASH_PROGRAMMER_ASSERT_SVH
`define BOOTLOADER_FLASH_PROGRAMMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define BFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/bfp_pkg.sv =====
// Shared constants, codes and the job descriptor of the flash programmer.
// Used by every module of the block but the queue; depends on nothing.
package bfp_pkg;

    localparam int CHUNK_BYTES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FLASH_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_BYTE    = 2'd3;

    localparam logic [31:0] FLASH_BASE_RST  = 32'h0800_0000;
    localparam logic [4:0]  SYNC_LIMIT_RST  = 5'd5;
    localparam logic [4:0]  ERASE_LIMIT_RST = 5'd20;
    localparam logic [7:0]  PAD_BYTE_RST    = 8'hFF;

    // protocol bytes
    localparam logic [7:0] ACK_BYTE      = 8'h79;
    localparam logic [7:0] SYNC_BYTE     = 8'h7F;
    localparam logic [7:0] ERASE_CMD     = 8'h43;
    localparam logic [7:0] ERASE_CMD_N   = 8'hBC;
    localparam logic [7:0] ERASE_ALL     = 8'hFF;
    localparam logic [7:0] ERASE_ALL_N   = 8'h00;
    localparam logic [7:0] WRITE_CMD     = 8'h31;
    localparam logic [7:0] WRITE_CMD_N   = 8'hCE;

    // request kinds on the input channel
    localparam logic [2:0] REQ_SYNC    = 3'd0;
    localparam logic [2:0] REQ_ERASE   = 3'd1;
    localparam logic [2:0] REQ_IMAGE   = 3'd2;
    localparam logic [2:0] REQ_RX      = 3'd3;
    localparam logic [2:0] REQ_TIMEOUT = 3'd4;

    // outcome codes
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_SYNCED  = 3'd1;
    localparam logic [2:0] ST_ERASED  = 3'd2;
    localparam logic [2:0] ST_CHUNK   = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;
    localparam logic [2:0] ST_NACK    = 3'd5;
    localparam logic [2:0] ST_RETRY   = 3'd6;
    localparam logic [2:0] ST_REJECT  = 3'd7;

    // what the back end has to send for one accepted item
    typedef enum logic [2:0] {
        JOB_NONE,
        JOB_SYNC,
        JOB_ERASE1,
        JOB_ERASE2,
        JOB_WCMD,
        JOB_WADDR,
        JOB_WDATA
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [2:0]  status;
        logic        rdy;
        logic [31:0] addr;
        logic [7:0]  pad;
    } job_t;

endpackage

// ===== rtl/bootloader_flash_programmer.sv =====
// Host-side serial bootloader flash programmer: front end, job queue, back end.
// First result path: job queue, then back-end job registers, then the output register.
// The back end sends one result per cycle while m_tready does not stall it, and pops the next
// job only after the last result of the current one; input stalls while a data frame reads the chunk store.
// Reset: aresetn synchronous active low; clears control and restores register defaults,
// the chunk store is not cleared.
module bootloader_flash_programmer #(
    parameter int CHUNK_BYTES = bfp_pkg::CHUNK_BYTES_DEF,
    parameter int QUEUE_DEPTH = bfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bfp_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [bfp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // last_byte
    input  logic [2:0]                     s_tuser,   // [2:0] req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [7:0] tx_byte, [10:8] status,
                                                      // [11] ready_res
    output logic                           m_tlast,   // run_last
    output logic                           m_tuser    // tx_valid
);

    import bfp_pkg::*;

    localparam int IDX_W  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int FILL_W = $clog2(CHUNK_BYTES + 1);
    localparam int JOB_W  = $bits(job_t);
    localparam int Q_W    = JOB_W + FILL_W;

    job_t              fe_job;
    logic [FILL_W-1:0] fe_fill;
    logic              fe_push;
    job_t              be_job;
    logic [FILL_W-1:0] be_fill;
    logic              be_pop;
    logic              q_full;
    logic              q_not_empty;
    logic [Q_W-1:0]    q_push_data;
    logic [Q_W-1:0]    q_pop_data;
    logic              data_done;
    logic              st_we;
    logic [IDX_W-1:0]  st_idx;
    logic [7:0]        st_data;

    assign q_push_data = {fe_fill, fe_job};
    assign be_job      = job_t'(q_pop_data[JOB_W-1:0]);
    assign be_fill     = q_pop_data[Q_W-1 -: FILL_W];

    bfp_front #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .s_tuser      (s_tuser),
        .job_push     (fe_push),
        .job          (fe_job),
        .job_fill     (fe_fill),
        .queue_full   (q_full),
        .data_done    (data_done),
        .st_we        (st_we),
        .st_idx       (st_idx),
        .st_data      (st_data)
    );

    bfp_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fe_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (be_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    bfp_back #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_not_empty),
        .job       (be_job),
        .job_fill  (be_fill),
        .job_pop   (be_pop),
        .st_we     (st_we),
        .st_idx    (st_idx),
        .st_data   (st_data),
        .data_done (data_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/bfp_queue.sv =====
// Short FIFO that carries job descriptors from the front end to the back end.
// Generic width and depth; depends on nothing.
module bfp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    logic [WIDTH-1:0] entry_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/bfp_front.sv =====
// Front end: configuration registers, protocol sequencer and chunk loading.
// Turns every accepted transaction into one job for the back end; uses bfp_pkg.
module bfp_front #(
    parameter int CHUNK_BYTES = bfp_pkg::CHUNK_BYTES_DEF,
    localparam int IDX_W  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1,
    localparam int FILL_W = $clog2(CHUNK_BYTES + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bfp_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [bfp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tlast,
    input  logic [2:0]                     s_tuser,
    output logic                           job_push,
    output bfp_pkg::job_t                  job,
    output logic [FILL_W-1:0]              job_fill,
    input  logic                           queue_full,
    input  logic                           data_done,
    output logic                           st_we,
    output logic [IDX_W-1:0]               st_idx,
    output logic [7:0]                     st_data
);

    import bfp_pkg::*;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_SYNC   = 8'b0000_0010,
        PH_ERASE1 = 8'b0000_0100,
        PH_ERASE2 = 8'b0000_1000,
        PH_LOAD   = 8'b0001_0000,
        PH_WCMD   = 8'b0010_0000,
        PH_WADDR  = 8'b0100_0000,
        PH_WDATA  = 8'b1000_0000
    } phase_t;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(CHUNK_BYTES);

    phase_t            phase_reg, phase_next;
    logic [4:0]        retry_reg, retry_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       addr_reg, addr_next;
    logic              final_reg, final_next;
    logic [7:0]        pad_reg, pad_next;
    logic              data_pend_reg;

    logic [31:0]       flash_base_reg;
    logic [4:0]        sync_limit_reg;
    logic [4:0]        erase_limit_reg;
    logic [7:0]        pad_cfg_reg;

    logic              accept;
    logic              waiting;
    logic              ack;
    logic [FILL_W-1:0] fill_after;
    logic [5:0]        retry_inc;

    // no new transaction while the queue is full or a data frame still reads the chunk store
    assign s_tready = !queue_full && !data_pend_reg;
    assign accept   = s_tvalid && s_tready;
    assign job_push = accept;

    always_comb begin
        phase_next = phase_reg;
        retry_next = retry_reg;
        fill_next  = fill_reg;
        addr_next  = addr_reg;
        final_next = final_reg;
        pad_next   = pad_reg;
        job.kind   = JOB_NONE;
        job.status = ST_REJECT;
        job.addr   = addr_reg;
        job.pad    = pad_reg;
        job.rdy    = 1'b0;
        job_fill   = fill_reg;
        st_we      = 1'b0;
        st_idx     = fill_reg[IDX_W-1:0];
        st_data    = s_tdata;
        fill_after = fill_reg;
        waiting    = !(phase_reg == PH_IDLE || phase_reg == PH_LOAD);
        ack        = (s_tuser == REQ_RX) && (s_tdata == ACK_BYTE);
        retry_inc  = {1'b0, retry_reg} + 6'd1;

        unique case (s_tuser) inside
            REQ_SYNC, REQ_ERASE: begin
                if (!waiting) begin
                    fill_next  = '0;
                    final_next = 1'b0;
                    job.status = ST_BUSY;
                    if (s_tuser == REQ_SYNC) begin
                        retry_next = 5'd1;
                        phase_next = PH_SYNC;
                        job.kind   = JOB_SYNC;
                    end else begin
                        phase_next = PH_ERASE1;
                        job.kind   = JOB_ERASE1;
                    end
                end
            end
            REQ_IMAGE: begin
                if (phase_reg == PH_LOAD) begin
                    if (fill_reg < FILL_FULL) begin
                        st_we      = accept;
                        fill_after = fill_reg + 1'b1;
                    end
                    fill_next  = fill_after;
                    job.status = ST_BUSY;
                    if (fill_after == FILL_FULL || s_tlast) begin
                        if (s_tlast) begin
                            final_next = 1'b1;
                            pad_next   = pad_cfg_reg;
                        end
                        phase_next = PH_WCMD;
                        job.kind   = JOB_WCMD;
                    end
                end
            end
            REQ_RX, REQ_TIMEOUT: begin
                if (waiting) begin
                    unique case (phase_reg)
                        PH_SYNC: begin
                            if (ack) begin
                                phase_next = PH_IDLE;
                                job.status = ST_SYNCED;
                            end else if (retry_reg >= sync_limit_reg) begin
                                phase_next = PH_IDLE;
                                fill_next  = '0;
                                final_next = 1'b0;
                                job.status = ST_RETRY;
                            end else begin
                                retry_next = retry_inc[4:0];
                                job.kind   = JOB_SYNC;
                                job.status = ST_BUSY;
                            end
                        end
                        PH_ERASE1: begin
                            if (ack) begin
                                retry_next = '0;
                                phase_next = PH_ERASE2;
                                job.kind   = JOB_ERASE2;
                                job.status = ST_BUSY;
                            end else begin
                                phase_next = PH_IDLE;
                                fill_next  = '0;
                                final_next = 1'b0;
                                job.status = ST_NACK;
                            end
                        end
                        PH_ERASE2: begin
                            if (ack) begin
                                addr_next  = flash_base_reg;
                                fill_next  = '0;
                                final_next = 1'b0;
                                phase_next = PH_LOAD;
                                job.status = ST_ERASED;
                            end else begin
                                retry_next = retry_inc[4:0];
                                if (retry_inc >= {1'b0, erase_limit_reg}) begin
                                    phase_next = PH_IDLE;
                                    fill_next  = '0;
                                    final_next = 1'b0;
                                    job.status = ST_RETRY;
                                end else begin
                                    job.status = ST_BUSY;
                                end
                            end
                        end
                        PH_WCMD, PH_WADDR, PH_WDATA: begin
                            if (!ack) begin
                                phase_next = PH_IDLE;
                                fill_next  = '0;
                                final_next = 1'b0;
                                job.status = ST_NACK;
                            end else if (phase_reg == PH_WCMD) begin
                                phase_next = PH_WADDR;
                                job.kind   = JOB_WADDR;
                                job.status = ST_BUSY;
                            end else if (phase_reg == PH_WADDR) begin
                                phase_next = PH_WDATA;
                                job.kind   = JOB_WDATA;
                                job.status = ST_BUSY;
                            end else begin
                                addr_next = addr_reg + 32'(CHUNK_BYTES);
                                fill_next = '0;
                                if (final_reg) begin
                                    final_next = 1'b0;
                                    phase_next = PH_IDLE;
                                    job.status = ST_DONE;
                                end else begin
                                    phase_next = PH_LOAD;
                                    job.status = ST_CHUNK;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        job.rdy = (phase_next == PH_IDLE) || (phase_next == PH_LOAD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            retry_reg     <= '0;
            fill_reg      <= '0;
            final_reg     <= 1'b0;
            data_pend_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                retry_reg <= retry_next;
                fill_reg  <= fill_next;
                final_reg <= final_next;
            end
            if (data_done) begin
                data_pend_reg <= 1'b0;
            end else if (accept && job.kind == JOB_WDATA) begin
                data_pend_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg <= addr_next;
            pad_reg  <= pad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_base_reg  <= FLASH_BASE_RST;
            sync_limit_reg  <= SYNC_LIMIT_RST;
            erase_limit_reg <= ERASE_LIMIT_RST;
            pad_cfg_reg     <= PAD_BYTE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_FLASH_BASE:  flash_base_reg  <= cfg_wr_data[31:0];
                REG_SYNC_LIMIT:  sync_limit_reg  <= cfg_wr_data[4:0];
                REG_ERASE_LIMIT: erase_limit_reg <= cfg_wr_data[4:0];
                REG_PAD_BYTE:    pad_cfg_reg     <= cfg_wr_data[7:0];
            endcase
        end
    end

endmodule

// ===== rtl/bfp_back.sv =====
// Back end: holds the chunk store and plays out each job byte by byte
// into the output register, with running XOR checksums; uses bfp_pkg.
module bfp_back #(
    parameter int CHUNK_BYTES = bfp_pkg::CHUNK_BYTES_DEF,
    localparam int IDX_W     = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1,
    localparam int FILL_W    = $clog2(CHUNK_BYTES + 1),
    localparam int FRAME_MAX = (CHUNK_BYTES + 2 > 5) ? CHUNK_BYTES + 2 : 5,
    localparam int CNT_W     = $clog2(FRAME_MAX)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    input  bfp_pkg::job_t     job,
    input  logic [FILL_W-1:0] job_fill,
    output logic              job_pop,
    input  logic              st_we,
    input  logic [IDX_W-1:0]  st_idx,
    input  logic [7:0]        st_data,
    output logic              data_done,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] tx_byte, [10:8] status, [11] ready_res
    output logic              m_tlast,   // run_last
    output logic              m_tuser    // tx_valid
);

    import bfp_pkg::*;

    localparam int MEM_DEPTH = 1 << IDX_W;
    localparam int CMP_W     = (CNT_W > FILL_W) ? CNT_W : FILL_W;
    localparam logic [7:0]       LEN_BYTE   = 8'(CHUNK_BYTES - 1);
    localparam logic [CNT_W-1:0] LAST_WDATA = CNT_W'(CHUNK_BYTES + 1);

    logic [7:0]        store_mem [MEM_DEPTH];
    logic [7:0]        rd_data_reg;

    logic              busy_reg;
    job_kind_t         kind_reg;
    logic [2:0]        status_reg;
    logic              rdy_reg;
    logic [31:0]       addr_reg;
    logic [7:0]        pad_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        xor_reg;

    logic              m_tvalid_reg;
    logic [7:0]        m_byte_reg;
    logic [2:0]        m_status_reg;
    logic              m_rdy_reg;
    logic              m_last_reg;
    logic              m_txv_reg;

    logic              out_free;
    logic              emit;
    logic              is_last;
    logic [CNT_W-1:0]  last_idx;
    logic [7:0]        tx_byte_c;
    logic              tx_valid_c;
    logic [CNT_W-1:0]  rd_idx_full;
    logic [IDX_W-1:0]  rd_idx;

    assign out_free = !m_tvalid_reg || m_tready;
    assign job_pop  = !busy_reg && job_valid;
    assign emit     = busy_reg && out_free;

    always_comb begin
        unique case (kind_reg)
            JOB_ERASE1, JOB_ERASE2, JOB_WCMD: last_idx = CNT_W'(1);
            JOB_WADDR:                        last_idx = CNT_W'(4);
            JOB_WDATA:                        last_idx = LAST_WDATA;
            default:                          last_idx = '0;
        endcase
    end

    assign is_last = (cnt_reg == last_idx);

    always_comb begin
        tx_valid_c = 1'b1;
        tx_byte_c  = '0;
        unique case (kind_reg)
            JOB_SYNC:   tx_byte_c = SYNC_BYTE;
            JOB_ERASE1: tx_byte_c = (cnt_reg == '0) ? ERASE_CMD : ERASE_CMD_N;
            JOB_ERASE2: tx_byte_c = (cnt_reg == '0) ? ERASE_ALL : ERASE_ALL_N;
            JOB_WCMD:   tx_byte_c = (cnt_reg == '0) ? WRITE_CMD : WRITE_CMD_N;
            JOB_WADDR: begin
                // address goes out most significant byte first
                if (cnt_reg == CNT_W'(0)) begin
                    tx_byte_c = addr_reg[31:24];
                end else if (cnt_reg == CNT_W'(1)) begin
                    tx_byte_c = addr_reg[23:16];
                end else if (cnt_reg == CNT_W'(2)) begin
                    tx_byte_c = addr_reg[15:8];
                end else if (cnt_reg == CNT_W'(3)) begin
                    tx_byte_c = addr_reg[7:0];
                end else begin
                    tx_byte_c = xor_reg;
                end
            end
            JOB_WDATA: begin
                if (cnt_reg == '0) begin
                    tx_byte_c = LEN_BYTE;
                end else if (is_last) begin
                    tx_byte_c = xor_reg;
                end else if (CMP_W'(cnt_reg) <= CMP_W'(fill_reg)) begin
                    tx_byte_c = rd_data_reg;
                end else begin
                    tx_byte_c = pad_reg;   // tail of a short final chunk
                end
            end
            default: tx_valid_c = 1'b0;
        endcase
    end

    always_comb begin
        if (job_pop) begin
            cnt_next = '0;
        end else if (emit && !is_last) begin
            cnt_next = cnt_reg + 1'b1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    // read one byte ahead so rd_data_reg matches the data byte at cnt_reg
    assign rd_idx_full = cnt_next - CNT_W'(1);
    assign rd_idx      = rd_idx_full[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_idx] <= st_data;
        end
        rd_data_reg <= store_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            kind_reg     <= JOB_NONE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (job_pop) begin
                busy_reg <= 1'b1;
                kind_reg <= job.kind;
            end else if (emit && is_last) begin
                busy_reg <= 1'b0;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            status_reg <= job.status;
            rdy_reg    <= job.rdy;
            addr_reg   <= job.addr;
            pad_reg    <= job.pad;
            fill_reg   <= job_fill;
            xor_reg    <= '0;
        end else if (emit) begin
            xor_reg <= xor_reg ^ tx_byte_c;
        end
        if (emit) begin
            m_byte_reg   <= tx_byte_c;
            m_status_reg <= status_reg;
            m_rdy_reg    <= rdy_reg;
            m_last_reg   <= is_last;
            m_txv_reg    <= tx_valid_c;
        end
    end

    assign data_done = emit && is_last && (kind_reg == JOB_WDATA);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_rdy_reg, m_status_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_txv_reg;

endmodule

// ===== rtl/bfp_checker.sv =====
// Port-level checks on the flash programmer result channel, bound to the top level.
// Uses bfp_pkg and the assertion macros header.
`include "bootloader_flash_programmer_assert.svh"

module bfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    import bfp_pkg::*;

    // a stalled result transaction keeps its contents
    `BFP_ASSERT_NEXT(stall_hold_chk, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // a result without a byte to send is alone in its run and carries a zero byte
    `BFP_ASSERT_IMPLY(empty_result_chk, aclk, aresetn, m_tvalid && !m_tuser, m_tlast && (m_tdata[7:0] == 8'h00))

    // any outcome other than busy comes from a transaction that sends nothing
    `BFP_ASSERT_IMPLY(outcome_no_tx_chk, aclk, aresetn, m_tvalid && (m_tdata[10:8] != ST_BUSY), !m_tuser)

    // the results of one run follow back to back with one status
    `BFP_ASSERT_NEXT(run_status_chk, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[10:8] == $past(m_tdata[10:8])))

endmodule

bind bootloader_flash_programmer bfp_checker u_bfp_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the bootloader flash programmer: sync, erase and chunked writes.
// Uses bfp_pkg for codes and protocol bytes; a built-in predictor computes every link byte.
`timescale 1ns / 100ps

module tb;
    import bfp_pkg::*;

    localparam int CHUNK_LEN = CHUNK_BYTES_DEF;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE, PH_SYNC, PH_ERASE1, PH_ERASE2, PH_LOAD, PH_WCMD, PH_WADDR, PH_WDATA
    } host_phase_t;

    typedef struct {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       run_last;
        logic [2:0] status;
        logic       ready_res;
    } link_result_t;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [1:0]  cfg_wr_index = '0;
    logic [31:0] cfg_wr_data  = '0;
    logic        s_tvalid     = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata      = '0;
    logic        s_tlast      = 1'b0;
    logic [2:0]  s_tuser      = '0;
    logic        m_tvalid;
    logic        m_tready     = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    bootloader_flash_programmer dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    // predictor state
    host_phase_t host_phase;
    int          attempts;
    logic [7:0]  chunk_buf [CHUNK_LEN];
    int          fill_cnt;
    logic [31:0] target_addr;
    logic        final_pending;
    logic [31:0] cfg_base;
    int          cfg_sync_lim;
    int          cfg_erase_lim;
    logic [7:0]  cfg_pad;

    logic [7:0]   frame_bytes [$];
    link_result_t link_expect [$];
    logic         last_rejected;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int accepted_items = 0;
    int mismatch_count = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("[bootloader_flash_programmer] ERROR");
        $finish;
    end

    function automatic void reset_host_model();
        cfg_base      = FLASH_BASE_RST;
        cfg_sync_lim  = int'(SYNC_LIMIT_RST);
        cfg_erase_lim = int'(ERASE_LIMIT_RST);
        cfg_pad       = PAD_BYTE_RST;
        host_phase    = PH_IDLE;
        attempts      = 0;
        fill_cnt      = 0;
        target_addr   = cfg_base;
        final_pending = 1'b0;
    endfunction

    // turn the queued link bytes of one transaction into expected results
    function automatic void close_run(input logic [2:0] st);
        link_result_t r;
        logic rdy;
        rdy = (host_phase == PH_IDLE) || (host_phase == PH_LOAD);
        r.status = st;
        r.ready_res = rdy;
        if (frame_bytes.size() == 0) begin
            r.tx_valid = 1'b0;
            r.tx_byte  = 8'h00;
            r.run_last = 1'b1;
            link_expect.push_back(r);
        end
        foreach (frame_bytes[k]) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = frame_bytes[k];
            r.run_last = (k == frame_bytes.size() - 1);
            link_expect.push_back(r);
        end
        last_rejected = (st == ST_REJECT);
        frame_bytes.delete();
    endfunction

    function automatic void abort_to_idle(input logic [2:0] st);
        host_phase    = PH_IDLE;
        fill_cnt      = 0;
        final_pending = 1'b0;
        close_run(st);
    endfunction

    function automatic void predict_link_bytes(input logic [2:0] req, input logic [7:0] dat,
                                               input logic last);
        logic       waiting;
        logic       ack;
        logic [7:0] x;
        waiting = !(host_phase == PH_IDLE || host_phase == PH_LOAD);
        ack = (req == REQ_RX) && (dat == ACK_BYTE);
        frame_bytes.delete();

        if (req == REQ_SYNC || req == REQ_ERASE) begin
            if (waiting) begin
                close_run(ST_REJECT);
                return;
            end
            fill_cnt = 0;
            final_pending = 1'b0;
            if (req == REQ_SYNC) begin
                attempts = 1;
                host_phase = PH_SYNC;
                frame_bytes.push_back(SYNC_BYTE);
            end else begin
                host_phase = PH_ERASE1;
                frame_bytes.push_back(ERASE_CMD);
                frame_bytes.push_back(ERASE_CMD_N);
            end
            close_run(ST_BUSY);
            return;
        end

        if (req == REQ_IMAGE) begin
            if (host_phase != PH_LOAD) begin
                close_run(ST_REJECT);
                return;
            end
            if (fill_cnt < CHUNK_LEN) begin
                chunk_buf[fill_cnt] = dat;
                fill_cnt++;
            end
            if (fill_cnt < CHUNK_LEN && !last) begin
                close_run(ST_BUSY);
                return;
            end
            if (last) begin
                final_pending = 1'b1;
                for (int i = fill_cnt; i < CHUNK_LEN; i++) chunk_buf[i] = cfg_pad;
            end
            host_phase = PH_WCMD;
            frame_bytes.push_back(WRITE_CMD);
            frame_bytes.push_back(WRITE_CMD_N);
            close_run(ST_BUSY);
            return;
        end

        if ((req != REQ_RX && req != REQ_TIMEOUT) || !waiting) begin
            close_run(ST_REJECT);
            return;
        end

        // a timeout is treated like any non-ACK reply
        case (host_phase)
            PH_SYNC: begin
                if (ack) begin
                    host_phase = PH_IDLE;
                    close_run(ST_SYNCED);
                end else if (attempts >= cfg_sync_lim) begin
                    abort_to_idle(ST_RETRY);
                end else begin
                    attempts++;
                    frame_bytes.push_back(SYNC_BYTE);
                    close_run(ST_BUSY);
                end
            end
            PH_ERASE1: begin
                if (!ack) begin
                    abort_to_idle(ST_NACK);
                end else begin
                    attempts = 0;
                    host_phase = PH_ERASE2;
                    frame_bytes.push_back(ERASE_ALL);
                    frame_bytes.push_back(ERASE_ALL_N);
                    close_run(ST_BUSY);
                end
            end
            PH_ERASE2: begin
                if (ack) begin
                    target_addr = cfg_base;
                    fill_cnt = 0;
                    final_pending = 1'b0;
                    host_phase = PH_LOAD;
                    close_run(ST_ERASED);
                end else begin
                    attempts++;
                    if (attempts >= cfg_erase_lim) abort_to_idle(ST_RETRY);
                    else close_run(ST_BUSY);
                end
            end
            PH_WCMD: begin
                if (!ack) begin
                    abort_to_idle(ST_NACK);
                end else begin
                    x = 8'h00;
                    for (int i = 0; i < 4; i++) begin
                        frame_bytes.push_back(target_addr[31 - 8 * i -: 8]);
                        x ^= target_addr[31 - 8 * i -: 8];
                    end
                    frame_bytes.push_back(x);
                    host_phase = PH_WADDR;
                    close_run(ST_BUSY);
                end
            end
            PH_WADDR: begin
                if (!ack) begin
                    abort_to_idle(ST_NACK);
                end else begin
                    x = 8'(CHUNK_LEN - 1);
                    frame_bytes.push_back(x);
                    for (int i = 0; i < CHUNK_LEN; i++) begin
                        x ^= chunk_buf[i];
                        frame_bytes.push_back(chunk_buf[i]);
                    end
                    frame_bytes.push_back(x);
                    host_phase = PH_WDATA;
                    close_run(ST_BUSY);
                end
            end
            PH_WDATA: begin
                if (!ack) begin
                    abort_to_idle(ST_NACK);
                end else begin
                    target_addr = target_addr + 32'(CHUNK_LEN);
                    fill_cnt = 0;
                    if (final_pending) begin
                        final_pending = 1'b0;
                        host_phase = PH_IDLE;
                        close_run(ST_DONE);
                    end else begin
                        host_phase = PH_LOAD;
                        close_run(ST_CHUNK);
                    end
                end
            end
            default: abort_to_idle(ST_REJECT);
        endcase
    endfunction

    // result side
    always @(posedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        link_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (link_expect.size() == 0) begin
                $error("unexpected result transaction: m_tdata %04h", m_tdata);
                mismatch_count++;
            end else begin
                exp_r = link_expect.pop_front();
                if (m_tuser !== exp_r.tx_valid) begin
                    $error("tx_valid: expected %0d, got %0d", exp_r.tx_valid, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[7:0] !== exp_r.tx_byte) begin
                    $error("tx_byte: expected %02h, got %02h", exp_r.tx_byte, m_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_tdata[10:8] !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tdata[10:8]);
                    mismatch_count++;
                end
                if (m_tdata[11] !== exp_r.ready_res) begin
                    $error("ready_res: expected %0d, got %0d", exp_r.ready_res, m_tdata[11]);
                    mismatch_count++;
                end
                if (m_tdata[15:12] !== 4'h0) begin
                    $error("tdata pad: expected 0, got %0h", m_tdata[15:12]);
                    mismatch_count++;
                end
                if (m_tlast !== exp_r.run_last) begin
                    $error("run_last: expected %0d, got %0d", exp_r.run_last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // input side
    task automatic send_request(input logic [2:0] req, input logic [7:0] dat, input logic last);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= dat;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_link_bytes(req, dat, last);
        if (!last_rejected) accepted_items++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        case (idx)
            REG_FLASH_BASE:  cfg_base = val;
            REG_SYNC_LIMIT:  cfg_sync_lim = int'(val[4:0]);
            REG_ERASE_LIMIT: cfg_erase_lim = int'(val[4:0]);
            REG_PAD_BYTE:    cfg_pad = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] base, input logic [4:0] sync_lim,
                              input logic [4:0] erase_lim, input logic [7:0] pad);
        write_reg(REG_FLASH_BASE, base);
        write_reg(REG_SYNC_LIMIT, 32'(sync_lim));
        write_reg(REG_ERASE_LIMIT, 32'(erase_lim));
        write_reg(REG_PAD_BYTE, 32'(pad));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (link_expect.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // reply as the target would, with a share of bad replies
    task automatic answer_target(input int err_pct);
        logic [7:0] b;
        logic       l;
        b = 8'($urandom_range(0, 255));
        l = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) >= err_pct) begin
            send_request(REQ_RX, ACK_BYTE, l);
        end else begin
            case ($urandom_range(0, 5))
                0, 1:    send_request(REQ_RX, b, l);
                2, 3:    send_request(REQ_TIMEOUT, b, l);
                4:       send_request(3'($urandom_range(0, 2)), b, l);
                default: send_request(3'($urandom_range(5, 7)), b, l);
            endcase
        end
    endtask

    task automatic settle(input int err_pct);
        while (!(host_phase == PH_IDLE || host_phase == PH_LOAD)) answer_target(err_pct);
    endtask

    task automatic run_session(input int img_len, input int err_pct);
        int pick;
        send_request(REQ_SYNC, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        settle(err_pct);
        send_request(REQ_ERASE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        settle(err_pct);
        for (int i = 0; i < img_len && host_phase == PH_LOAD; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                // stray reply or timeout while loading is rejected
                send_request(3'($urandom_range(3, 4)), 8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 4) begin
                // restart while loading drops the buffered bytes
                send_request(3'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
            end
            if (host_phase == PH_LOAD)
                send_request(REQ_IMAGE, 8'($urandom_range(0, 255)), i == img_len - 1);
            settle(err_pct);
        end
    endtask

    task automatic test_rejects_when_idle();
        send_request(REQ_RX, ACK_BYTE, 1'b0);
        send_request(REQ_TIMEOUT, 8'hFF, 1'b1);
        send_request(REQ_IMAGE, 8'hA5, 1'b1);
        send_request(REQ_UNUSED_HI, 8'h00, 1'b0);
    endtask

    task automatic test_sync_handshake();
        send_request(REQ_SYNC, 8'h00, 1'b0);
        send_request(REQ_RX, 8'h00, 1'b0);
        send_request(REQ_TIMEOUT, 8'h00, 1'b0);
        send_request(REQ_RX, ACK_BYTE, 1'b0);
    endtask

    task automatic test_erase_and_short_image();
        send_request(REQ_ERASE, 8'h00, 1'b0);
        send_request(REQ_RX, ACK_BYTE, 1'b0);
        send_request(REQ_SYNC, 8'h00, 1'b0);
        send_request(REQ_TIMEOUT, 8'h00, 1'b0);
        send_request(REQ_RX, ACK_BYTE, 1'b0);
        send_request(REQ_IMAGE, 8'h00, 1'b0);
        send_request(REQ_IMAGE, 8'hFF, 1'b0);
        send_request(REQ_IMAGE, 8'h5A, 1'b1);
        repeat (3) send_request(REQ_RX, ACK_BYTE, 1'b0);
    endtask

    task automatic test_zero_retry_limits();
        drain_results();
        set_config(32'hFFFF_FFF0, 5'd0, 5'd0, 8'h00);
        send_request(REQ_SYNC, 8'h00, 1'b0);
        send_request(REQ_TIMEOUT, 8'h00, 1'b0);
        send_request(REQ_ERASE, 8'h00, 1'b0);
        send_request(REQ_RX, ACK_BYTE, 1'b0);
        send_request(REQ_RX, 8'h7A, 1'b1);
        send_request(REQ_ERASE, 8'h00, 1'b0);
        send_request(REQ_TIMEOUT, 8'h00, 1'b0);
        send_request(REQ_UNUSED_LO, 8'h00, 1'b1);
    endtask

    task automatic test_random_sessions(input int quota, input int idle_pct, input int stall_pct,
                                        input logic [31:0] base, input logic [4:0] sync_lim,
                                        input logic [4:0] erase_lim, input logic [7:0] pad);
        int start;
        int pick;
        int img_len;
        drain_results();
        set_config(base, sync_lim, erase_lim, pad);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = accepted_items;
        while (accepted_items - start < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                settle(10);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 10) img_len = CHUNK_LEN * $urandom_range(1, 2);
                else if (pick < 15) img_len = $urandom_range(41, 64);
                else img_len = $urandom_range(1, 40);
                run_session(img_len, $urandom_range(0, 20));
            end
        end
    endtask

    initial begin
        reset_host_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_rejects_when_idle();
        test_sync_handshake();
        test_erase_and_short_image();
        test_zero_retry_limits();

        test_random_sessions(45, 0, 0, FLASH_BASE_RST, 5'd5, 5'd20, 8'hFF);
        test_random_sessions(45, 79, 0, 32'hFFFF_FFF0, 5'd31, 5'd31, 8'h00);
        test_random_sessions(45, 0, 79, $urandom, 5'($urandom_range(1, 4)),
                             5'($urandom_range(1, 6)), 8'($urandom_range(0, 255)));
        test_random_sessions(45, 13, 13, 32'h0000_0000, 5'd1, 5'd1, 8'($urandom_range(0, 255)));

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[bootloader_flash_programmer] OK");
        end else begin
            $display("[bootloader_flash_programmer] ERROR");
        end
        $finish;
    end

endmodule
